@@ src/trm_pkg.sv @@
`default_nettype none
package trm_pkg;

  localparam int PC_W  = 4;
  localparam int DIV_W = 32;

  localparam logic [15:0] MINUTE_MS = 16'd60000;

  localparam logic [1:0] CFG_LOW_RATE  = 2'd0;
  localparam logic [1:0] CFG_HIGH_RATE = 2'd1;
  localparam logic [1:0] CFG_GAP       = 2'd2;
  localparam logic [1:0] CFG_TAPS      = 2'd3;

  localparam logic [1:0] REM_NONE  = 2'd0;
  localparam logic [1:0] REM_SLOW  = 2'd1;
  localparam logic [1:0] REM_SPEED = 2'd2;

  localparam logic [PC_W-1:0] STEP_WAIT     = PC_W'(0);
  localparam logic [PC_W-1:0] STEP_TAP      = PC_W'(1);
  localparam logic [PC_W-1:0] STEP_SPAN     = PC_W'(2);
  localparam logic [PC_W-1:0] STEP_DIV_MEAN = PC_W'(3);
  localparam logic [PC_W-1:0] STEP_RATE     = PC_W'(4);
  localparam logic [PC_W-1:0] STEP_DIV_RATE = PC_W'(5);
  localparam logic [PC_W-1:0] STEP_SET_Q    = PC_W'(6);
  localparam logic [PC_W-1:0] STEP_SET_SAT  = PC_W'(7);
  localparam logic [PC_W-1:0] STEP_SET_ZERO = PC_W'(8);
  localparam logic [PC_W-1:0] STEP_REMIND   = PC_W'(9);
  localparam logic [PC_W-1:0] STEP_LAST     = STEP_REMIND;

  typedef enum logic [3:0] {
    OP_ACCEPT,
    OP_TAP,
    OP_LOAD_SPAN,
    OP_DIV_STEP,
    OP_LOAD_RATE,
    OP_SET_RATE_Q,
    OP_SET_RATE_SAT,
    OP_SET_RATE_ZERO,
    OP_REMIND
  } trm_op_t;

  typedef enum logic [2:0] {
    COND_NEVER,
    COND_ALWAYS,
    COND_NO_IN,
    COND_NO_TAP,
    COND_FEW_TAPS,
    COND_DIV_MORE,
    COND_MEAN_ZERO,
    COND_OUT_BUSY
  } trm_cond_t;

  typedef struct packed {
    trm_op_t         op;
    trm_cond_t       cond;
    logic [PC_W-1:0] target;
  } trm_uword_t;

  typedef struct packed {
    logic no_in;
    logic no_tap;
    logic few_taps;
    logic div_more;
    logic mean_zero;
    logic out_busy;
  } trm_flags_t;

  // Microprogram. A taken condition jumps to target, otherwise the step counter advances.
  function automatic trm_uword_t trm_ucode(input logic [PC_W-1:0] pc);
    trm_uword_t w;
    unique case (pc)
      STEP_WAIT:     w = '{OP_ACCEPT,        COND_NO_IN,     STEP_WAIT};
      STEP_TAP:      w = '{OP_TAP,           COND_NO_TAP,    STEP_REMIND};
      STEP_SPAN:     w = '{OP_LOAD_SPAN,     COND_FEW_TAPS,  STEP_SET_ZERO};
      STEP_DIV_MEAN: w = '{OP_DIV_STEP,      COND_DIV_MORE,  STEP_DIV_MEAN};
      STEP_RATE:     w = '{OP_LOAD_RATE,     COND_MEAN_ZERO, STEP_SET_SAT};
      STEP_DIV_RATE: w = '{OP_DIV_STEP,      COND_DIV_MORE,  STEP_DIV_RATE};
      STEP_SET_Q:    w = '{OP_SET_RATE_Q,    COND_ALWAYS,    STEP_REMIND};
      STEP_SET_SAT:  w = '{OP_SET_RATE_SAT,  COND_ALWAYS,    STEP_REMIND};
      STEP_SET_ZERO: w = '{OP_SET_RATE_ZERO, COND_NEVER,     STEP_WAIT};
      STEP_REMIND:   w = '{OP_REMIND,        COND_OUT_BUSY,  STEP_REMIND};
      default:       w = '{OP_ACCEPT,        COND_ALWAYS,    STEP_WAIT};
    endcase
    return w;
  endfunction

endpackage
`default_nettype wire

@@ src/tap_rate_monitor_unit.sv @@
`default_nettype none
// Tap tempo meter. Each input beat is one poll: a millisecond timestamp and a
// tap-released flag. Every accepted beat yields exactly one output beat with the
// held rate in taps per minute and a reminder code (0 none, 1 slow down, 2 speed up).
// Configuration is written through cfg_we/cfg_index/cfg_wdata; the user must do so
// only while the block is idle, which the block itself does not enforce. One poll is
// handled at a time. in_stall is low only while rst_n is high and the microprogram
// waits for a poll. A poll without a tap goes from the wait step to the tap step and
// on to the reminder step, which loads the output register; a tap with too few taps
// passes the span and set-zero steps first; a full rate update runs the divider, one
// quotient bit per cycle, over all 32 bits of the mean interval and then of the rate.
// The output register lets the next poll be accepted while a result still waits;
// only when the register is still held by out_stall does the sequencer wait at its
// last step, and with it the input side.
// A synchronous reset (rst_n low) restores the register defaults, empties the tap
// count and ring pointer, clears the rate and reminder time, and drops out_valid.
// The tap ring is not cleared; only written slots are ever used for a rate.
module tap_rate_monitor_unit #(
  parameter int RING_DEPTH = 32
) (
  input  wire         clk,
  input  wire         rst_n,
  input  wire         cfg_we,
  input  wire [1:0]   cfg_index,
  input  wire [31:0]  cfg_wdata,
  input  wire         in_valid,
  output logic        in_stall,
  input  wire [31:0]  in_now_ms,
  input  wire         in_tap_released,
  output logic        out_valid,
  input  wire         out_stall,
  output logic [15:0] out_rate_per_minute,
  output logic [1:0]  out_reminder
);
  import trm_pkg::*;

  trm_uword_t uword;
  trm_flags_t flags;
  logic       idle;

  trm_sequencer u_seq (
    .clk   (clk),
    .rst_n (rst_n),
    .flags (flags),
    .uword (uword),
    .idle  (idle)
  );

  trm_datapath #(.RING_DEPTH(RING_DEPTH)) u_dp (
    .clk                 (clk),
    .rst_n               (rst_n),
    .cfg_we              (cfg_we),
    .cfg_index           (cfg_index),
    .cfg_wdata           (cfg_wdata),
    .in_valid            (in_valid),
    .in_now_ms           (in_now_ms),
    .in_tap_released     (in_tap_released),
    .out_stall           (out_stall),
    .out_valid           (out_valid),
    .out_rate_per_minute (out_rate_per_minute),
    .out_reminder        (out_reminder),
    .uword               (uword),
    .flags               (flags)
  );

  assign in_stall = !idle || !rst_n;

endmodule
`default_nettype wire

@@ src/trm_divider.sv @@
`default_nettype none
module trm_divider (
  input  wire                       clk,
  input  wire                       rst_n,
  input  wire                       load,
  input  wire                       step,
  input  wire [trm_pkg::DIV_W-1:0]  dividend,
  input  wire [trm_pkg::DIV_W-1:0]  divisor,
  output logic [trm_pkg::DIV_W-1:0] quotient,
  output logic                      more
);
  import trm_pkg::*;

  localparam int CW = $clog2(DIV_W);

  logic [DIV_W-1:0] rem_r, rem_nxt;
  logic [DIV_W-1:0] quo_r, quo_nxt;
  logic [DIV_W-1:0] dvs_r;
  logic [CW-1:0]    cnt_r;
  logic [DIV_W:0]   trial;

  // Restoring division, one quotient bit per step, dividend bits shift out of the top.
  always_comb begin
    trial = {rem_r, quo_r[DIV_W-1]} - {1'b0, dvs_r};
    if (!trial[DIV_W]) begin
      rem_nxt = trial[DIV_W-1:0];
      quo_nxt = {quo_r[DIV_W-2:0], 1'b1};
    end else begin
      rem_nxt = {rem_r[DIV_W-2:0], quo_r[DIV_W-1]};
      quo_nxt = {quo_r[DIV_W-2:0], 1'b0};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
    end else if (load) begin
      cnt_r <= '0;
    end else if (step) begin
      cnt_r <= cnt_r + CW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      rem_r <= '0;
      quo_r <= dividend;
      dvs_r <= divisor;
    end else if (step) begin
      rem_r <= rem_nxt;
      quo_r <= quo_nxt;
    end
  end

  assign quotient = quo_r;
  assign more     = (cnt_r != CW'(DIV_W - 1));

endmodule
`default_nettype wire

@@ src/trm_datapath.sv @@
`default_nettype none
module trm_datapath #(
  parameter int RING_DEPTH = 32
) (
  input  wire                 clk,
  input  wire                 rst_n,
  input  wire                 cfg_we,
  input  wire [1:0]           cfg_index,
  input  wire [31:0]          cfg_wdata,
  input  wire                 in_valid,
  input  wire [31:0]          in_now_ms,
  input  wire                 in_tap_released,
  input  wire                 out_stall,
  output logic                out_valid,
  output logic [15:0]         out_rate_per_minute,
  output logic [1:0]          out_reminder,
  input  trm_pkg::trm_uword_t uword,
  output trm_pkg::trm_flags_t flags
);
  import trm_pkg::*;

  localparam int IDX_W = $clog2(RING_DEPTH);
  localparam int KMAX  = (RING_DEPTH < 32) ? RING_DEPTH : 32;
  localparam int OW    = (IDX_W + 1 > 6) ? IDX_W + 1 : 6;

  logic [15:0]      low_r, high_r;
  logic [31:0]      gap_r;
  logic [5:0]       taps_cfg_r;
  logic [31:0]      now_r;
  logic             tap_r;
  logic [IDX_W-1:0] slot_r;
  logic [5:0]       seen_r;
  logic [15:0]      rate_r;
  logic [31:0]      last_r;
  logic [31:0]      rd_r;
  logic             out_valid_r;
  logic [15:0]      out_rate_r;
  logic [1:0]       out_rem_r;

  logic [31:0]      ring_mem [RING_DEPTH];

  logic [5:0]       k, km1;
  logic [OW-1:0]    slot_e, km1_e, oldest_e;
  logic [IDX_W-1:0] oldest;
  logic [31:0]      elapsed;
  logic [1:0]       code;
  logic             tap_do, do_remind;
  logic             div_load, div_step, div_more;
  logic [31:0]      div_dividend, div_quotient;

  always_comb begin
    k = taps_cfg_r;
    if (k < 6'd2) k = 6'd2;
    if (k > 6'(KMAX)) k = 6'(KMAX);
    km1 = k - 6'd1;
  end

  // Oldest slot of the window, wrapping back through the ring.
  always_comb begin
    slot_e = OW'(slot_r);
    km1_e  = OW'(km1);
    if (slot_e >= km1_e) oldest_e = slot_e - km1_e;
    else                 oldest_e = slot_e + OW'(RING_DEPTH) - km1_e;
    oldest = oldest_e[IDX_W-1:0];
  end

  // A slow-down reminder wins over a speed-up one when both thresholds are crossed.
  always_comb begin
    elapsed = now_r - last_r;
    if (rate_r > high_r && elapsed > gap_r)     code = REM_SLOW;
    else if (rate_r < low_r && elapsed > gap_r) code = REM_SPEED;
    else                                        code = REM_NONE;
  end

  assign tap_do    = (uword.op == OP_TAP) && tap_r;
  assign do_remind = (uword.op == OP_REMIND) && !flags.out_busy;
  assign div_load  = (uword.op == OP_LOAD_SPAN) || (uword.op == OP_LOAD_RATE);
  assign div_step  = (uword.op == OP_DIV_STEP);
  assign div_dividend = (uword.op == OP_LOAD_SPAN) ? (now_r - rd_r) : 32'(MINUTE_MS);

  trm_divider u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .load     (div_load),
    .step     (div_step),
    .dividend (div_dividend),
    .divisor  ((uword.op == OP_LOAD_SPAN) ? 32'(km1) : div_quotient),
    .quotient (div_quotient),
    .more     (div_more)
  );

  always_ff @(posedge clk) begin
    if (tap_do) ring_mem[slot_r] <= now_r;
    if (uword.op == OP_TAP) rd_r <= ring_mem[oldest];
  end

  always_ff @(posedge clk) begin
    if (uword.op == OP_ACCEPT && in_valid) begin
      now_r <= in_now_ms;
      tap_r <= in_tap_released;
    end
    if (do_remind) begin
      out_rate_r <= rate_r;
      out_rem_r  <= code;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      low_r       <= 16'd10;
      high_r      <= 16'd20;
      gap_r       <= 32'd5000;
      taps_cfg_r  <= 6'd4;
      slot_r      <= '0;
      seen_r      <= '0;
      rate_r      <= '0;
      last_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          CFG_LOW_RATE:  low_r      <= cfg_wdata[15:0];
          CFG_HIGH_RATE: high_r     <= cfg_wdata[15:0];
          CFG_GAP:       gap_r      <= cfg_wdata;
          CFG_TAPS:      taps_cfg_r <= cfg_wdata[5:0];
          default:       ;
        endcase
      end
      if (tap_do) begin
        slot_r <= (slot_r == IDX_W'(RING_DEPTH - 1)) ? '0 : slot_r + IDX_W'(1);
        if (seen_r != 6'd63) seen_r <= seen_r + 6'd1;
      end
      case (uword.op)
        OP_SET_RATE_Q:    rate_r <= div_quotient[15:0];
        OP_SET_RATE_SAT:  rate_r <= MINUTE_MS;
        OP_SET_RATE_ZERO: rate_r <= '0;
        default:          ;
      endcase
      if (do_remind && code != REM_NONE) last_r <= now_r;
      if (do_remind)       out_valid_r <= 1'b1;
      else if (!out_stall) out_valid_r <= 1'b0;
    end
  end

  always_comb begin
    flags.no_in     = !in_valid;
    flags.no_tap    = !tap_r;
    flags.few_taps  = seen_r < k;
    flags.div_more  = div_more;
    flags.mean_zero = (div_quotient == '0);
    flags.out_busy  = out_valid_r && out_stall;
  end

  assign out_valid           = out_valid_r;
  assign out_rate_per_minute = out_rate_r;
  assign out_reminder        = out_rem_r;

endmodule
`default_nettype wire

@@ src/trm_sequencer.sv @@
`default_nettype none
module trm_sequencer (
  input  wire                 clk,
  input  wire                 rst_n,
  input  trm_pkg::trm_flags_t flags,
  output trm_pkg::trm_uword_t uword,
  output logic                idle
);
  import trm_pkg::*;

  logic [PC_W-1:0] pc_r, pc_nxt;
  logic            take;

  assign uword = trm_ucode(pc_r);

  always_comb begin
    case (uword.cond)
      COND_NEVER:     take = 1'b0;
      COND_ALWAYS:    take = 1'b1;
      COND_NO_IN:     take = flags.no_in;
      COND_NO_TAP:    take = flags.no_tap;
      COND_FEW_TAPS:  take = flags.few_taps;
      COND_DIV_MORE:  take = flags.div_more;
      COND_MEAN_ZERO: take = flags.mean_zero;
      COND_OUT_BUSY:  take = flags.out_busy;
      default:        take = 1'b0;
    endcase
    if (take)                   pc_nxt = uword.target;
    else if (pc_r == STEP_LAST) pc_nxt = STEP_WAIT;
    else                        pc_nxt = pc_r + PC_W'(1);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) pc_r <= STEP_WAIT;
    else        pc_r <= pc_nxt;
  end

  assign idle = (pc_r == STEP_WAIT);

endmodule
`default_nettype wire

@@ src/trm_checker.sv @@
`default_nettype none
module trm_checker (
  input wire        clk,
  input wire        rst_n,
  input wire        in_valid,
  input wire        in_stall,
  input wire        out_valid,
  input wire        out_stall,
  input wire [15:0] out_rate_per_minute,
  input wire [1:0]  out_reminder
);

  // Reset empties the output register.
  a_reset_empty: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("output beat present after reset");

  // An accepted poll keeps the input side busy in the next cycle.
  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && !in_stall) |=> in_stall)
    else $error("input accepted again without processing");

  a_rate_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_rate_per_minute <= 16'd60000 && out_reminder != 2'd3))
    else $error("result out of range");

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_stall) |=> out_valid)
    else $error("stalled output beat dropped");

endmodule

bind tap_rate_monitor_unit trm_checker u_trm_checker (.*);
`default_nettype wire

@@ test/tap_rate_monitor_unit_test.sv @@
`default_nettype none
module tap_rate_monitor_unit_test;
  timeunit 1ns;
  timeprecision 1ps;

  import trm_pkg::*;

  localparam int RING_DEPTH = 32;
  localparam int unsigned TAP_COUNT_MAX = 63;
  localparam int PHASES = 8;
  localparam int POLLS_PER_PHASE = 175;

  typedef struct packed {
    logic [15:0] rate;
    logic [1:0]  reminder;
  } reading_t;

  typedef enum logic {ROW_POLL, ROW_CFG} row_kind_t;

  typedef struct {
    row_kind_t   kind;
    logic [1:0]  sel;
    logic [31:0] value;
    logic        tap;
    bit          typed;
    reading_t    want;
  } dir_row_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        cfg_we = 1'b0;
  logic [1:0]  cfg_index = CFG_LOW_RATE;
  logic [31:0] cfg_wdata = '0;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic [31:0] in_now_ms = '0;
  logic        in_tap_released = 1'b0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic [15:0] out_rate_per_minute;
  logic [1:0]  out_reminder;

  // Meter state as seen from outside, kept in step with every accepted poll.
  logic [31:0] tap_ring [RING_DEPTH];
  int unsigned ring_wr = 0;
  int unsigned tap_count = 0;
  logic [15:0] held_rate = '0;
  logic [31:0] last_remind = '0;
  logic [15:0] lim_low = 16'd10;
  logic [15:0] lim_high = 16'd20;
  logic [31:0] lim_gap = 32'd5000;
  logic [5:0]  tap_k = 6'd4;

  reading_t    readings [$];
  int unsigned mismatches = 0;
  int unsigned burst_left = 0;

  tap_rate_monitor_unit #(
    .RING_DEPTH(RING_DEPTH)
  ) i_dut (
    .clk(clk),
    .rst_n(rst_n),
    .cfg_we(cfg_we),
    .cfg_index(cfg_index),
    .cfg_wdata(cfg_wdata),
    .in_valid(in_valid),
    .in_stall(in_stall),
    .in_now_ms(in_now_ms),
    .in_tap_released(in_tap_released),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_rate_per_minute(out_rate_per_minute),
    .out_reminder(out_reminder)
  );

  initial begin
    forever #10 clk = ~clk;
  end

  function automatic reading_t meter_poll(input logic [31:0] now, input logic tap);
    int unsigned k;
    int unsigned oldest;
    logic [31:0] span;
    logic [31:0] mean;
    reading_t    r;
    k = (tap_k < 2) ? 2 : (tap_k > 32) ? 32 : tap_k;
    if (k > RING_DEPTH) k = RING_DEPTH;
    if (tap) begin
      tap_ring[ring_wr] = now;
      if (tap_count < TAP_COUNT_MAX) tap_count++;
      if (tap_count >= k) begin
        // The window holds the new tap and the k-1 taps written before it.
        oldest = (ring_wr + RING_DEPTH - (k - 1)) % RING_DEPTH;
        span = now - tap_ring[oldest];
        mean = span / (k - 1);
        held_rate = (mean == 0) ? MINUTE_MS : 16'(32'(MINUTE_MS) / mean);
      end else begin
        held_rate = '0;
      end
      ring_wr = (ring_wr + 1) % RING_DEPTH;
    end
    r.rate = held_rate;
    r.reminder = REM_NONE;
    if (held_rate > lim_high && 32'(now - last_remind) > lim_gap) begin
      r.reminder = REM_SLOW;
      last_remind = now;
    end
    // A slow-down reminder moves the reminder time to now, which blocks this one.
    if (held_rate < lim_low && 32'(now - last_remind) > lim_gap) begin
      r.reminder = REM_SPEED;
      last_remind = now;
    end
    return r;
  endfunction

  function automatic dir_row_t poll_row(input logic [31:0] now, input logic tap,
                                        input logic [15:0] rate, input logic [1:0] rem);
    dir_row_t row;
    row = '{ROW_POLL, CFG_LOW_RATE, now, tap, 1'b1, '{rate, rem}};
    return row;
  endfunction

  function automatic dir_row_t open_row(input logic [31:0] now, input logic tap);
    dir_row_t row;
    row = '{ROW_POLL, CFG_LOW_RATE, now, tap, 1'b0, '{16'd0, REM_NONE}};
    return row;
  endfunction

  function automatic dir_row_t cfg_row(input logic [1:0] sel, input logic [31:0] value);
    dir_row_t row;
    row = '{ROW_CFG, sel, value, 1'b0, 1'b0, '{16'd0, REM_NONE}};
    return row;
  endfunction

  task automatic write_reg(input logic [1:0] sel, input logic [31:0] value);
    cfg_we <= 1'b1;
    cfg_index <= sel;
    cfg_wdata <= value;
    @(posedge clk);
    cfg_we <= 1'b0;
    case (sel)
      CFG_LOW_RATE:  lim_low = value[15:0];
      CFG_HIGH_RATE: lim_high = value[15:0];
      CFG_GAP:       lim_gap = value;
      CFG_TAPS:      tap_k = value[5:0];
    endcase
    @(posedge clk);
  endtask

  // Sender works in bursts; a burst may start after a random pause.
  task automatic offer_poll(input logic [31:0] now, input logic tap, input bit typed,
                            input reading_t typed_reading);
    int unsigned gap;
    reading_t    predicted;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 24);
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 30);
      if (gap != 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    burst_left--;
    in_valid <= 1'b1;
    in_now_ms <= now;
    in_tap_released <= tap;
    do @(posedge clk); while (in_stall);
    predicted = meter_poll(now, tap);
    readings.push_back(typed ? typed_reading : predicted);
  endtask

  task automatic settle();
    in_valid <= 1'b0;
    while (readings.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  // Receiver stall pattern: free running, random, sparse or heavy, in runs.
  initial begin
    int unsigned run;
    int unsigned style;
    forever begin
      style = $urandom_range(0, 3);
      run = $urandom_range(1, 60);
      repeat (run) begin
        case (style)
          0:       out_stall <= 1'b0;
          1:       out_stall <= 1'($urandom_range(0, 1));
          2:       out_stall <= ($urandom_range(0, 7) == 0);
          default: out_stall <= ($urandom_range(0, 3) != 0);
        endcase
        @(posedge clk);
      end
    end
  end

  always @(posedge clk) begin
    reading_t want;
    if (rst_n && out_valid === 1'b1 && !out_stall) begin
      if (readings.size() == 0) begin
        $display("%0t: unexpected beat, rate %0d reminder %0d", $time,
                 out_rate_per_minute, out_reminder);
        mismatches++;
      end else begin
        want = readings.pop_front();
        if (out_rate_per_minute !== want.rate) begin
          $display("%0t: rate expected %0d actual %0d", $time, want.rate,
                   out_rate_per_minute);
          mismatches++;
        end
        if (out_reminder !== want.reminder) begin
          $display("%0t: reminder expected %0d actual %0d", $time, want.reminder,
                   out_reminder);
          mismatches++;
        end
      end
    end
  end

  initial begin
    dir_row_t    directed [$];
    logic [31:0] sim_ms;
    logic [31:0] now;
    logic        tap;
    int unsigned pick;
    int unsigned lo;
    int unsigned hi;
    int unsigned k_raw;
    logic [31:0] gap_ms;

    // Reset defaults: low 10, high 20, gap 5000 ms, four taps averaged.
    directed.push_back(poll_row(32'd0, 1'b0, 16'd0, REM_NONE));
    directed.push_back(poll_row(32'd5001, 1'b0, 16'd0, REM_SPEED));
    directed.push_back(poll_row(32'hFFFF_FFFF, 1'b0, 16'd0, REM_SPEED));
    directed.push_back(poll_row(32'd6000, 1'b1, 16'd0, REM_SPEED));
    directed.push_back(poll_row(32'd6500, 1'b1, 16'd0, REM_NONE));
    directed.push_back(poll_row(32'd7000, 1'b1, 16'd0, REM_NONE));
    directed.push_back(poll_row(32'd7500, 1'b1, 16'd120, REM_NONE));
    directed.push_back(poll_row(32'd11001, 1'b0, 16'd120, REM_SLOW));
    directed.push_back(open_row(32'd11010, 1'b1));
    directed.push_back(open_row(32'd11010, 1'b1));
    directed.push_back(open_row(32'd11010, 1'b1));
    // Four equal timestamps: zero mean interval saturates the rate.
    directed.push_back(poll_row(32'd11010, 1'b1, MINUTE_MS, REM_NONE));
    directed.push_back(cfg_row(CFG_TAPS, 32'd0));
    directed.push_back(cfg_row(CFG_LOW_RATE, 32'd0));
    directed.push_back(cfg_row(CFG_HIGH_RATE, 32'(MINUTE_MS)));
    directed.push_back(cfg_row(CFG_GAP, 32'd0));
    directed.push_back(poll_row(32'd11011, 1'b1, MINUTE_MS, REM_NONE));
    directed.push_back(poll_row(32'd71012, 1'b1, 16'd0, REM_NONE));
    directed.push_back(cfg_row(CFG_LOW_RATE, 32'(MINUTE_MS)));
    directed.push_back(cfg_row(CFG_HIGH_RATE, 32'd0));
    directed.push_back(poll_row(32'd71013, 1'b0, 16'd0, REM_SPEED));
    // Both thresholds crossed: only the slow-down reminder is given.
    directed.push_back(poll_row(32'd72012, 1'b1, 16'd60, REM_SLOW));
    directed.push_back(open_row(32'hFFFF_FFF0, 1'b1));
    directed.push_back(poll_row(32'h0000_0010, 1'b1, 16'd1875, REM_SLOW));
    directed.push_back(cfg_row(CFG_GAP, 32'hFFFF_FFFF));
    directed.push_back(cfg_row(CFG_TAPS, 32'd63));
    directed.push_back(poll_row(32'h8000_0000, 1'b0, 16'd1875, REM_NONE));
    directed.push_back(poll_row(32'h8000_0001, 1'b1, 16'd0, REM_NONE));

    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (directed[i]) begin
      if (directed[i].kind == ROW_CFG) begin
        settle();
        write_reg(directed[i].sel, directed[i].value);
      end else begin
        offer_poll(directed[i].value, directed[i].tap, directed[i].typed, directed[i].want);
      end
    end

    sim_ms = 32'h8000_0100;
    for (int phase = 0; phase < PHASES; phase++) begin
      settle();
      case (phase)
        0: begin
          k_raw = 63;
          lo = 0;
          hi = MINUTE_MS;
          gap_ms = 32'hFFFF_FFFF;
        end
        1: begin
          k_raw = 32;
          lo = 100;
          hi = 200;
          gap_ms = 32'd0;
        end
        2: begin
          k_raw = 1;
          lo = MINUTE_MS;
          hi = 0;
          gap_ms = 32'd5000;
        end
        default: begin
          k_raw = $urandom_range(0, 63);
          lo = ($urandom_range(0, 3) == 0) ? $urandom_range(0, MINUTE_MS) : $urandom_range(20, 150);
          hi = (lo > MINUTE_MS - 300) ? MINUTE_MS : lo + $urandom_range(0, 300);
          case ($urandom_range(0, 3))
            0:       gap_ms = 32'd0;
            1:       gap_ms = $urandom_range(1, 2000);
            2:       gap_ms = 32'd5000;
            default: gap_ms = $urandom;
          endcase
        end
      endcase
      // Bits above each register's width are junk and must be dropped.
      write_reg(CFG_LOW_RATE, {16'($urandom), 16'(lo)});
      write_reg(CFG_HIGH_RATE, {16'($urandom), 16'(hi)});
      write_reg(CFG_GAP, gap_ms);
      write_reg(CFG_TAPS, {26'($urandom), 6'(k_raw)});

      for (int n = 0; n < POLLS_PER_PHASE; n++) begin
        pick = $urandom_range(0, 99);
        if (pick < 78) begin
          // Regular 50 ms style polling with a tap now and then.
          sim_ms += $urandom_range(0, 120);
          tap = ($urandom_range(0, 5) == 0);
          now = sim_ms;
        end else if (pick < 84) begin
          tap = 1'b1;
          now = sim_ms;
        end else if (pick < 90) begin
          sim_ms += $urandom_range(1000, 70000);
          tap = 1'($urandom_range(0, 1));
          now = sim_ms;
        end else if (pick < 94) begin
          sim_ms = $urandom;
          tap = 1'($urandom_range(0, 1));
          now = sim_ms;
        end else begin
          now = $urandom;
          tap = 1'($urandom_range(0, 1));
        end
        offer_poll(now, tap, 1'b0, '{16'd0, REM_NONE});
      end
    end

    settle();
    repeat (100) @(posedge clk);
    if (mismatches == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

  initial begin
    #40_000_000;
    $display("CHECK FAILED");
    $finish;
  end

endmodule
`default_nettype wire
